/* rtl/cci_pkg.sv */
package cci_pkg;

    localparam int WORD_W      = 32;
    localparam int FRAC_BITS   = 16;
    localparam int BOUNCE_BITS = 16;
    localparam int NORM_BITS   = 30;

    // shared shape of every pipelined divider: 64-bit dividend, 33-bit divisor
    localparam int DIV_DW = 33;
    localparam int DIV_QW = 31;
    localparam int DIV_NW = DIV_DW + DIV_QW;

    // square root: 64-bit radicand, 32-bit root, one root bit per stage
    localparam int SQRT_IW = 2 * WORD_W;
    localparam int SQRT_RW = WORD_W;

    localparam logic [BOUNCE_BITS:0] BOUNCE_ONE = 17'h10000;

    typedef enum logic [1:0] {
        ST_APART   = 2'd0,
        ST_COIN    = 2'd1,
        ST_SEP     = 2'd2,
        ST_IMPULSE = 2'd3
    } status_t;

    // carried alongside the square root
    typedef struct packed {
        logic        v;
        logic        apart;
        logic        coin;
        logic        sgx;
        logic        sgy;
        logic [32:0] rvx;
        logic [32:0] rvy;
        logic [31:0] dxm;
        logic [31:0] dym;
        logic [31:0] rsum;
    } aux_sq_t;

    // carried alongside the dividers
    typedef struct packed {
        logic        v;
        logic        apart;
        logic        coin;
        logic        sgx;
        logic        sgy;
        logic [32:0] rvx;
        logic [32:0] rvy;
    } aux_dv_t;

endpackage

/* rtl/cci_delay.sv */
module cci_delay #(
    parameter int W     = 1,
    parameter int DEPTH = 1
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);

    logic [W-1:0] line_reg [DEPTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                line_reg[i] <= '0;
            end
        end
        else
        begin
            line_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++)
            begin
                line_reg[i] <= line_reg[i-1];
            end
        end
    end

    assign dout = line_reg[DEPTH-1];

endmodule

/* rtl/cci_sqrt.sv */
module cci_sqrt (
    input  logic                         clk,
    input  logic [cci_pkg::SQRT_IW-1:0] radicand,
    output logic [cci_pkg::SQRT_RW-1:0] root
);

    localparam int IW = cci_pkg::SQRT_IW;
    localparam int RW = cci_pkg::SQRT_RW;
    localparam int EW = RW + 4;

    logic [EW-1:0] rem_reg  [RW];
    logic [RW-1:0] root_reg [RW];
    logic [IW-1:0] rad_reg  [RW];

    for (genvar i = 0; i < RW; i++)
    begin : g_stage
        logic [EW-1:0] rem_in;
        logic [RW-1:0] root_in;
        logic [IW-1:0] rad_in;
        logic [EW-1:0] cur;
        logic [EW-1:0] trial;
        logic [EW-1:0] rem_next;
        logic [RW-1:0] root_next;

        if (i == 0)
        begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = radicand;
        end
        else
        begin : g_rest
            assign rem_in  = rem_reg[i-1];
            assign root_in = root_reg[i-1];
            assign rad_in  = rad_reg[i-1];
        end

        always_comb
        begin
            cur   = {rem_in[EW-3:0], rad_in[IW-1:IW-2]};
            trial = {2'b00, root_in, 2'b01};
            if (cur >= trial)
            begin
                rem_next  = cur - trial;
                root_next = {root_in[RW-2:0], 1'b1};
            end
            else
            begin
                rem_next  = cur;
                root_next = {root_in[RW-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[i]  <= rem_next;
            root_reg[i] <= root_next;
            rad_reg[i]  <= {rad_in[IW-3:0], 2'b00};
        end
    end

    assign root = root_reg[RW-1];

endmodule

/* rtl/cci_div.sv */
// restoring divider, one quotient bit per stage; quotient must fit DIV_QW bits
module cci_div (
    input  logic                        clk,
    input  logic [cci_pkg::DIV_NW-1:0] dividend,
    input  logic [cci_pkg::DIV_DW-1:0] divisor,
    output logic [cci_pkg::DIV_QW-1:0] quotient
);

    localparam int NW = cci_pkg::DIV_NW;
    localparam int DW = cci_pkg::DIV_DW;
    localparam int QW = cci_pkg::DIV_QW;

    logic [DW-1:0] rem_reg [QW];
    logic [QW-1:0] quo_reg [QW];
    logic [QW-1:0] low_reg [QW];
    logic [DW-1:0] dv_reg  [QW];

    for (genvar i = 0; i < QW; i++)
    begin : g_stage
        logic [DW-1:0] rem_in;
        logic [QW-1:0] quo_in;
        logic [QW-1:0] low_in;
        logic [DW-1:0] dv_in;
        logic [DW:0]   cur;
        logic [DW:0]   diff;
        logic          ge;

        if (i == 0)
        begin : g_first
            assign rem_in = dividend[NW-1:QW];
            assign quo_in = '0;
            assign low_in = dividend[QW-1:0];
            assign dv_in  = divisor;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[i-1];
            assign quo_in = quo_reg[i-1];
            assign low_in = low_reg[i-1];
            assign dv_in  = dv_reg[i-1];
        end

        always_comb
        begin
            cur  = {rem_in, low_in[QW-1]};
            diff = cur - {1'b0, dv_in};
            ge   = (cur >= {1'b0, dv_in});
        end

        always_ff @(posedge clk)
        begin
            rem_reg[i] <= ge ? diff[DW-1:0] : cur[DW-1:0];
            quo_reg[i] <= {quo_in[QW-2:0], ge};
            low_reg[i] <= {low_in[QW-2:0], 1'b0};
            dv_reg[i]  <= dv_in;
        end
    end

    assign quotient = quo_reg[QW-1];

endmodule

/* rtl/circle_collision_impulse.sv */
// Channel    Signals                                        Handshake
// ---------  ---------------------------------------------  -----------------------------
// pair in    a_*/b_* pos, vel, radius, mass                 start && !busy
// result     contact_status, shift_x/y, push_x/y            done, one cycle, no back-pressure
// config     psel, penable, pwrite, paddr, pwdata, prdata   APB write, pready tied high
//
// Fully pipelined: one pair per cycle, busy is never raised. From the accepting edge to done
// a pair passes the 32-stage square root, then the 31-stage dividers for the normal and the
// shift, then the impulse multiply chain.
// Reset clears the valid chain and sets bounce to 1.0. No stalls on either side.
module circle_collision_impulse (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] a_pos_x,
    input  logic signed [31:0] a_pos_y,
    input  logic signed [31:0] a_vel_x,
    input  logic signed [31:0] a_vel_y,
    input  logic        [30:0] a_radius,
    input  logic        [30:0] a_mass,
    input  logic signed [31:0] b_pos_x,
    input  logic signed [31:0] b_pos_y,
    input  logic signed [31:0] b_vel_x,
    input  logic signed [31:0] b_vel_y,
    input  logic        [30:0] b_radius,
    input  logic        [30:0] b_mass,
    output logic               done,
    output logic        [1:0]  contact_status,
    output logic signed [31:0] shift_x,
    output logic signed [31:0] shift_y,
    output logic signed [31:0] push_x,
    output logic signed [31:0] push_y,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic        [2:0]  paddr,
    input  logic        [31:0] pwdata,
    output logic        [31:0] prdata,
    output logic               pready
);

    localparam int BB = cci_pkg::BOUNCE_BITS;
    localparam int NB = cci_pkg::NORM_BITS;

    // ---------------- configuration ----------------
    logic [BB:0] bounce_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bounce_reg <= cci_pkg::BOUNCE_ONE;
        end
        else if (psel && penable && pwrite && !paddr[2])
        begin
            bounce_reg <= pwdata[BB:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {{(31 - BB){1'b0}}, bounce_reg};
    assign busy   = 1'b0;

    // ---------------- stage A: differences ----------------
    logic               a_v_reg;
    logic        [32:0] a_dx_reg, a_dy_reg, a_rvx_reg, a_rvy_reg;
    logic        [31:0] a_rsum_reg;
    logic        [30:0] a_ma_reg, a_mb_reg;

    always_ff @(posedge clk)
    begin
        a_dx_reg   <= {b_pos_x[31], b_pos_x} - {a_pos_x[31], a_pos_x};
        a_dy_reg   <= {b_pos_y[31], b_pos_y} - {a_pos_y[31], a_pos_y};
        a_rvx_reg  <= {b_vel_x[31], b_vel_x} - {a_vel_x[31], a_vel_x};
        a_rvy_reg  <= {b_vel_y[31], b_vel_y} - {a_vel_y[31], a_vel_y};
        a_rsum_reg <= {1'b0, a_radius} + {1'b0, b_radius};
        a_ma_reg   <= a_mass;
        a_mb_reg   <= b_mass;
    end

    // ---------------- stage B: squares, mass product ----------------
    logic        b_v_reg;
    logic [31:0] b_dxm_reg, b_dym_reg, b_rsum_reg;
    logic        b_sgx_reg, b_sgy_reg;
    logic [32:0] b_rvx_reg, b_rvy_reg;
    logic [63:0] b_sqx_reg, b_sqy_reg, b_rsq_reg;
    logic [63:0] b_mp_reg;
    logic [32:0] b_msum_reg;
    logic [32:0] dxm_full, dym_full, msum_next;

    always_comb
    begin
        dxm_full  = a_dx_reg[32] ? (33'd0 - a_dx_reg) : a_dx_reg;
        dym_full  = a_dy_reg[32] ? (33'd0 - a_dy_reg) : a_dy_reg;
        msum_next = {2'b00, a_ma_reg} + {2'b00, a_mb_reg};
    end

    always_ff @(posedge clk)
    begin
        b_dxm_reg  <= dxm_full[31:0];
        b_dym_reg  <= dym_full[31:0];
        b_sgx_reg  <= a_dx_reg[32];
        b_sgy_reg  <= a_dy_reg[32];
        b_rvx_reg  <= a_rvx_reg;
        b_rvy_reg  <= a_rvy_reg;
        b_rsum_reg <= a_rsum_reg;
        b_sqx_reg  <= dxm_full[31:0] * dxm_full[31:0];
        b_sqy_reg  <= dym_full[31:0] * dym_full[31:0];
        b_rsq_reg  <= a_rsum_reg * a_rsum_reg;
        b_mp_reg   <= {33'd0, a_ma_reg} * {33'd0, a_mb_reg};
        // both masses zero: divide 0 by 1 so mu comes out zero
        b_msum_reg <= (msum_next == '0) ? 33'd1 : msum_next;
    end

    // ---------------- stage C: distance test ----------------
    logic        c_v_reg;
    logic        c_apart_reg, c_coin_reg;
    logic [63:0] c_dist2_reg;
    logic [31:0] c_dxm_reg, c_dym_reg, c_rsum_reg;
    logic        c_sgx_reg, c_sgy_reg;
    logic [32:0] c_rvx_reg, c_rvy_reg;
    logic [64:0] dist2_full;

    assign dist2_full = {1'b0, b_sqx_reg} + {1'b0, b_sqy_reg};

    always_ff @(posedge clk)
    begin
        c_apart_reg <= dist2_full[64] || (dist2_full[63:0] >= b_rsq_reg);
        c_coin_reg  <= (dist2_full == '0);
        c_dist2_reg <= dist2_full[63:0];
        c_dxm_reg   <= b_dxm_reg;
        c_dym_reg   <= b_dym_reg;
        c_rsum_reg  <= b_rsum_reg;
        c_sgx_reg   <= b_sgx_reg;
        c_sgy_reg   <= b_sgy_reg;
        c_rvx_reg   <= b_rvx_reg;
        c_rvy_reg   <= b_rvy_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
        end
        else
        begin
            a_v_reg <= start && !busy;
            b_v_reg <= a_v_reg;
            c_v_reg <= b_v_reg;
        end
    end

    // ---------------- reduced mass divider, runs beside the root ----------------
    logic [cci_pkg::DIV_QW-1:0] mu_q, mu_al;

    cci_div u_div_mu (
        .clk      (clk),
        .dividend (b_mp_reg),
        .divisor  (b_msum_reg),
        .quotient (mu_q)
    );

    cci_delay #(.W(cci_pkg::DIV_QW), .DEPTH(cci_pkg::SQRT_RW + 4)) u_dly_mu (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (mu_q),
        .dout  (mu_al)
    );

    // ---------------- square root ----------------
    logic [31:0]      root;
    cci_pkg::aux_sq_t aux_c, aux_s;

    cci_sqrt u_sqrt (
        .clk      (clk),
        .radicand (c_dist2_reg),
        .root     (root)
    );

    always_comb
    begin
        aux_c.v     = c_v_reg;
        aux_c.apart = c_apart_reg;
        aux_c.coin  = c_coin_reg;
        aux_c.sgx   = c_sgx_reg;
        aux_c.sgy   = c_sgy_reg;
        aux_c.rvx   = c_rvx_reg;
        aux_c.rvy   = c_rvy_reg;
        aux_c.dxm   = c_dxm_reg;
        aux_c.dym   = c_dym_reg;
        aux_c.rsum  = c_rsum_reg;
    end

    cci_delay #(.W($bits(cci_pkg::aux_sq_t)), .DEPTH(cci_pkg::SQRT_RW)) u_dly_sq (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (aux_c),
        .dout  (aux_s)
    );

    // ---------------- stage D: overlap products ----------------
    logic [63:0]      d_px_reg, d_py_reg;
    logic [31:0]      d_dxm_reg, d_dym_reg, d_root_reg;
    cci_pkg::aux_dv_t d_aux_reg, aux_e;
    logic [31:0]      ovl;

    assign ovl = aux_s.rsum - root;

    always_ff @(posedge clk)
    begin
        d_px_reg   <= ovl * aux_s.dxm;
        d_py_reg   <= ovl * aux_s.dym;
        d_dxm_reg  <= aux_s.dxm;
        d_dym_reg  <= aux_s.dym;
        d_root_reg <= root;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_aux_reg <= '0;
        end
        else
        begin
            d_aux_reg.v     <= aux_s.v;
            d_aux_reg.apart <= aux_s.apart;
            d_aux_reg.coin  <= aux_s.coin;
            d_aux_reg.sgx   <= aux_s.sgx;
            d_aux_reg.sgy   <= aux_s.sgy;
            d_aux_reg.rvx   <= aux_s.rvx;
            d_aux_reg.rvy   <= aux_s.rvy;
        end
    end

    // ---------------- normal and shift dividers ----------------
    logic [cci_pkg::DIV_QW-1:0] nxm_q, nym_q, shx_q, shy_q;

    cci_div u_div_nx (
        .clk      (clk),
        .dividend ({2'b00, d_dxm_reg, {NB{1'b0}}}),
        .divisor  ({1'b0, d_root_reg}),
        .quotient (nxm_q)
    );

    cci_div u_div_ny (
        .clk      (clk),
        .dividend ({2'b00, d_dym_reg, {NB{1'b0}}}),
        .divisor  ({1'b0, d_root_reg}),
        .quotient (nym_q)
    );

    cci_div u_div_sx (
        .clk      (clk),
        .dividend (d_px_reg),
        .divisor  ({d_root_reg, 1'b0}),
        .quotient (shx_q)
    );

    cci_div u_div_sy (
        .clk      (clk),
        .dividend (d_py_reg),
        .divisor  ({d_root_reg, 1'b0}),
        .quotient (shy_q)
    );

    cci_delay #(.W($bits(cci_pkg::aux_dv_t)), .DEPTH(cci_pkg::DIV_QW)) u_dly_dv (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (d_aux_reg),
        .dout  (aux_e)
    );

    // ---------------- stage F: velocity projections ----------------
    logic                     f_v_reg, g_v_reg, h_v_reg, i_v_reg, j_v_reg, k_v_reg;
    logic                     f_apart_reg, f_coin_reg, f_sgx_reg, f_sgy_reg;
    logic [30:0]              f_nxm_reg, f_nym_reg, f_shx_reg, f_shy_reg;
    logic signed [64:0]       f_prx_reg, f_pry_reg;
    logic signed [31:0]       nx_s, ny_s;

    always_comb
    begin
        nx_s = aux_e.sgx ? (32'sd0 - $signed({1'b0, nxm_q})) : $signed({1'b0, nxm_q});
        ny_s = aux_e.sgy ? (32'sd0 - $signed({1'b0, nym_q})) : $signed({1'b0, nym_q});
    end

    always_ff @(posedge clk)
    begin
        f_apart_reg <= aux_e.apart;
        f_coin_reg  <= aux_e.coin;
        f_sgx_reg   <= aux_e.sgx;
        f_sgy_reg   <= aux_e.sgy;
        f_nxm_reg   <= nxm_q;
        f_nym_reg   <= nym_q;
        f_shx_reg   <= shx_q;
        f_shy_reg   <= shy_q;
        f_prx_reg   <= $signed(aux_e.rvx) * nx_s;
        f_pry_reg   <= $signed(aux_e.rvy) * ny_s;
    end

    // ---------------- stage G: sign test, shift words ----------------
    cci_pkg::status_t   g_status_reg, h_status_reg, i_status_reg, j_status_reg, k_status_reg;
    logic signed [31:0] g_shx_reg, g_shy_reg, h_shx_reg, h_shy_reg, i_shx_reg, i_shy_reg;
    logic signed [31:0] j_shx_reg, j_shy_reg, k_shx_reg, k_shy_reg;
    logic [32:0]        g_vn_reg;
    logic [30:0]        g_nxm_reg, g_nym_reg, h_nxm_reg, h_nym_reg, i_nxm_reg, i_nym_reg;
    logic [30:0]        j_nxm_reg, j_nym_reg;
    logic               g_sgx_reg, g_sgy_reg, h_sgx_reg, h_sgy_reg, i_sgx_reg, i_sgy_reg;
    logic               j_sgx_reg, j_sgy_reg, k_sgx_reg, k_sgy_reg;
    logic signed [64:0] dot;
    logic [64:0]        dot_mag;
    cci_pkg::status_t   status_next;
    logic               touching;

    always_comb
    begin
        dot      = f_prx_reg + f_pry_reg;
        dot_mag  = dot[64] ? (65'd0 - dot) : dot;
        touching = !f_apart_reg && !f_coin_reg;
        if (f_apart_reg)
        begin
            status_next = cci_pkg::ST_APART;
        end
        else if (f_coin_reg)
        begin
            status_next = cci_pkg::ST_COIN;
        end
        else if (!dot[64] && dot != '0)
        begin
            status_next = cci_pkg::ST_SEP;
        end
        else
        begin
            status_next = cci_pkg::ST_IMPULSE;
        end
    end

    always_ff @(posedge clk)
    begin
        g_status_reg <= status_next;
        g_vn_reg     <= dot_mag[NB+32:NB];
        g_nxm_reg    <= f_nxm_reg;
        g_nym_reg    <= f_nym_reg;
        g_sgx_reg    <= f_sgx_reg;
        g_sgy_reg    <= f_sgy_reg;
        // quotient stays below 2^31, so no clamp is needed
        if (!touching)
        begin
            g_shx_reg <= '0;
            g_shy_reg <= '0;
        end
        else
        begin
            g_shx_reg <= f_sgx_reg ? (32'sd0 - $signed({1'b0, f_shx_reg}))
                                   : $signed({1'b0, f_shx_reg});
            g_shy_reg <= f_sgy_reg ? (32'sd0 - $signed({1'b0, f_shy_reg}))
                                   : $signed({1'b0, f_shy_reg});
        end
    end

    // ---------------- stages H..K: impulse magnitude ----------------
    logic [63:0] h_p_reg;
    logic [49:0] i_plo_reg, i_phi_reg;
    logic [50:0] j_j_reg;
    logic [62:0] k_qlox_reg, k_qloy_reg;
    logic [49:0] k_qhix_reg, k_qhiy_reg;
    logic [BB:0] e_clamp;
    logic [BB+1:0] kfac;

    always_comb
    begin
        e_clamp = (bounce_reg > cci_pkg::BOUNCE_ONE) ? cci_pkg::BOUNCE_ONE : bounce_reg;
        kfac    = {1'b0, cci_pkg::BOUNCE_ONE} + {1'b0, e_clamp};
    end

    always_ff @(posedge clk)
    begin
        h_p_reg      <= g_vn_reg * mu_al;
        h_status_reg <= g_status_reg;
        h_shx_reg    <= g_shx_reg;
        h_shy_reg    <= g_shy_reg;
        h_nxm_reg    <= g_nxm_reg;
        h_nym_reg    <= g_nym_reg;
        h_sgx_reg    <= g_sgx_reg;
        h_sgy_reg    <= g_sgy_reg;

        i_plo_reg    <= h_p_reg[31:0] * kfac;
        i_phi_reg    <= h_p_reg[63:32] * kfac;
        i_status_reg <= h_status_reg;
        i_shx_reg    <= h_shx_reg;
        i_shy_reg    <= h_shy_reg;
        i_nxm_reg    <= h_nxm_reg;
        i_nym_reg    <= h_nym_reg;
        i_sgx_reg    <= h_sgx_reg;
        i_sgy_reg    <= h_sgy_reg;

        j_j_reg      <= {1'b0, i_phi_reg} + {33'd0, i_plo_reg[49:32]};
        j_status_reg <= i_status_reg;
        j_shx_reg    <= i_shx_reg;
        j_shy_reg    <= i_shy_reg;
        j_nxm_reg    <= i_nxm_reg;
        j_nym_reg    <= i_nym_reg;
        j_sgx_reg    <= i_sgx_reg;
        j_sgy_reg    <= i_sgy_reg;

        k_qlox_reg   <= j_j_reg[31:0] * j_nxm_reg;
        k_qloy_reg   <= j_j_reg[31:0] * j_nym_reg;
        k_qhix_reg   <= j_j_reg[50:32] * j_nxm_reg;
        k_qhiy_reg   <= j_j_reg[50:32] * j_nym_reg;
        k_status_reg <= j_status_reg;
        k_shx_reg    <= j_shx_reg;
        k_shy_reg    <= j_shy_reg;
        k_sgx_reg    <= j_sgx_reg;
        k_sgy_reg    <= j_sgy_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_v_reg <= 1'b0;
            g_v_reg <= 1'b0;
            h_v_reg <= 1'b0;
            i_v_reg <= 1'b0;
            j_v_reg <= 1'b0;
            k_v_reg <= 1'b0;
        end
        else
        begin
            f_v_reg <= aux_e.v;
            g_v_reg <= f_v_reg;
            h_v_reg <= g_v_reg;
            i_v_reg <= h_v_reg;
            j_v_reg <= i_v_reg;
            k_v_reg <= j_v_reg;
        end
    end

    // ---------------- output stage: push, saturate ----------------
    logic               done_reg;
    cci_pkg::status_t   out_status_reg;
    logic signed [31:0] out_shx_reg, out_shy_reg, out_pshx_reg, out_pshy_reg;
    logic [52:0]        totx, toty;
    logic [31:0]        magx, magy;
    logic               impulse;

    always_comb
    begin
        totx    = {1'b0, k_qhix_reg, 2'b00} + {20'd0, k_qlox_reg[62:NB]};
        toty    = {1'b0, k_qhiy_reg, 2'b00} + {20'd0, k_qloy_reg[62:NB]};
        impulse = (k_status_reg == cci_pkg::ST_IMPULSE);
        // negative side may reach -2^31, positive side stops at 2^31-1
        if (totx > 53'h7FFFFFFF)
        begin
            magx = k_sgx_reg ? 32'h80000000 : 32'h7FFFFFFF;
        end
        else
        begin
            magx = totx[31:0];
        end
        if (toty > 53'h7FFFFFFF)
        begin
            magy = k_sgy_reg ? 32'h80000000 : 32'h7FFFFFFF;
        end
        else
        begin
            magy = toty[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        out_status_reg <= k_status_reg;
        out_shx_reg    <= k_shx_reg;
        out_shy_reg    <= k_shy_reg;
        out_pshx_reg   <= !impulse ? 32'sd0 : (k_sgx_reg ? $signed(32'd0 - magx) : $signed(magx));
        out_pshy_reg   <= !impulse ? 32'sd0 : (k_sgy_reg ? $signed(32'd0 - magy) : $signed(magy));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= k_v_reg;
        end
    end

    assign done           = done_reg;
    assign contact_status = out_status_reg;
    assign shift_x        = out_shx_reg;
    assign shift_y        = out_shy_reg;
    assign push_x         = out_pshx_reg;
    assign push_y         = out_pshy_reg;

endmodule
